>>> hdl/sdlq_pkg.sv
`default_nettype none
package sdlq_pkg;

  localparam int SBOX_BITS_DEF = 8;
  localparam int FIELD_W       = 8;
  localparam int VALUE_W       = 10;
  localparam int HALF_DIVISOR  = 2;
  localparam int VALUE_MAX     = 511;
  localparam int VALUE_MIN     = -512;

  typedef logic [1:0] op_t;

  localparam op_t OP_LOAD = 2'd0;
  localparam op_t OP_DDT  = 2'd1;
  localparam op_t OP_LAT  = 2'd2;

  localparam logic KIND_DDT = 1'b0;
  localparam logic KIND_LAT = 1'b1;

  typedef struct packed {
    op_t                op;
    logic [FIELD_W-1:0] entry_index;
    logic [FIELD_W-1:0] entry_value;
    logic [FIELD_W-1:0] in_word;
    logic [FIELD_W-1:0] out_word;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] table_value;
    logic                      table_kind;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic capture;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> hdl/sdlq_dp.sv
`default_nettype none
module sdlq_dp #(
  parameter int SBOX_BITS = sdlq_pkg::SBOX_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sdlq_pkg::in_item_t  in_data,
  input  wire sdlq_pkg::dp_cmd_t   cmd,
  output sdlq_pkg::dp_stat_t       stat,
  output sdlq_pkg::out_item_t      out_data
);
  import sdlq_pkg::*;

  localparam int DEPTH = 1 << SBOX_BITS;
  localparam int CNT_W = SBOX_BITS + 1;
  localparam int EXT_W = (SBOX_BITS + 2 > VALUE_W + 1) ? SBOX_BITS + 2 : VALUE_W + 1;
  localparam int HALF  = DEPTH / HALF_DIVISOR;

  localparam logic signed [EXT_W-1:0] HALF_EXT = EXT_W'(HALF);
  localparam logic signed [EXT_W-1:0] VMAX     = EXT_W'(VALUE_MAX);
  localparam logic signed [EXT_W-1:0] VMIN     = EXT_W'(VALUE_MIN);

  logic [SBOX_BITS-1:0] sbox_mem_r [DEPTH];
  logic [SBOX_BITS-1:0] a_r;
  logic [SBOX_BITS-1:0] b_r;
  logic                 kind_r;
  logic [SBOX_BITS-1:0] x_r;
  logic [SBOX_BITS-1:0] x_d_r;
  logic [SBOX_BITS-1:0] rd0_r;
  logic [SBOX_BITS-1:0] rd1_r;
  logic                 rd_vld_r;
  logic [CNT_W-1:0]     acc_r;
  out_item_t            out_r;

  logic                     match;
  logic signed [EXT_W-1:0]  acc_ext;
  logic signed [EXT_W-1:0]  raw_val;
  logic signed [EXT_W-1:0]  sat_val;
  out_item_t                out_nxt;

  // sbox store, one write port and two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sbox_mem_r[SBOX_BITS'(in_data.entry_index)] <= SBOX_BITS'(in_data.entry_value);
    end
    rd0_r <= sbox_mem_r[x_r];
    rd1_r <= sbox_mem_r[x_r ^ a_r];
  end

  always_comb begin
    if (kind_r == KIND_LAT) begin
      match = (^(a_r & x_d_r)) == (^(b_r & rd0_r));
    end else begin
      match = (rd0_r ^ rd1_r) == b_r;
    end
  end

  always_comb begin
    acc_ext = EXT_W'(acc_r);
    raw_val = (kind_r == KIND_LAT) ? acc_ext - HALF_EXT : acc_ext;
    if (raw_val > VMAX) begin
      sat_val = VMAX;
    end else if (raw_val < VMIN) begin
      sat_val = VMIN;
    end else begin
      sat_val = raw_val;
    end
    out_nxt.table_value = sat_val[VALUE_W-1:0];
    out_nxt.table_kind  = kind_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r    <= SBOX_BITS'(in_data.in_word);
      b_r    <= SBOX_BITS'(in_data.out_word);
      kind_r <= (in_data.op == OP_LAT) ? KIND_LAT : KIND_DDT;
      x_r    <= '0;
      acc_r  <= '0;
    end else begin
      if (cmd.issue) begin
        x_r   <= x_r + SBOX_BITS'(1);
        x_d_r <= x_r;
      end
      if (rd_vld_r && match) begin
        acc_r <= acc_r + CNT_W'(1);
      end
    end
    if (cmd.capture) begin
      out_r <= out_nxt;
    end
  end

  assign stat.last = (x_r == '1);
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> hdl/sdlq_ctrl.sv
`default_nettype none
module sdlq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sdlq_pkg::op_t     in_op,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sdlq_pkg::dp_cmd_t      cmd,
  input  wire sdlq_pkg::dp_stat_t stat
);
  import sdlq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    cmd.load    = in_acc && (in_op == OP_LOAD);
    cmd.start   = in_acc && ((in_op == OP_DDT) || (in_op == OP_LAT));
    cmd.issue   = (state_r == S_WALK);
    cmd.capture = (state_r == S_FINISH) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (cmd.capture) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> hdl/sbox_ddt_lat_query.sv
// channel | direction | payload    | handshake
// in      | input     | in_item_t  | in_valid / in_ready
// out     | output    | out_item_t | out_valid / out_ready
//
// a load beat writes one store entry; a query walks the store one entry per
// cycle through a dual-read memory, then passes a flush and a finish state;
// the result becomes valid in the same cycle that the next beat can be taken
// no clearing pass at reset; entries read before being loaded are undefined
// a result waits in the output register while loads are taken; a query that
// finishes while the previous result is still unread holds until it drains
`default_nettype none
module sbox_ddt_lat_query #(
  parameter int SBOX_BITS = sdlq_pkg::SBOX_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sdlq_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sdlq_pkg::out_item_t      out_data
);
  import sdlq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sdlq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_data.op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sdlq_dp #(
    .SBOX_BITS (SBOX_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> hdl/sdlq_chk.sv
`default_nettype none
module sdlq_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire sdlq_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire sdlq_pkg::out_item_t out_data
);
  import sdlq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_ddt_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.table_kind == KIND_DDT) |-> !out_data.table_value[VALUE_W-1])
    else $error("negative difference count");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && ((in_data.op == OP_DDT) || (in_data.op == OP_LAT))
    |=> !in_ready)
    else $error("input taken during a query walk");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == OP_LOAD) && !out_valid |=> !out_valid)
    else $error("load beat produced a result");

endmodule

bind sbox_ddt_lat_query sdlq_chk u_sdlq_chk (.*);
`default_nettype wire
